FILE: rtl/rpr_pkg.sv
// Package for the RSP packet receiver: character codes, controller states,
// command and status structs shared by controller and datapath.
// No dependencies.
package rpr_pkg;

	localparam logic [7:0] CH_START = 8'h24; // '$'
	localparam logic [7:0] CH_END   = 8'h23; // '#'
	localparam logic [7:0] CH_SEQ   = 8'h3a; // ':'
	localparam logic [7:0] CH_ACK   = 8'h2b; // '+'
	localparam logic [7:0] CH_NAK   = 8'h2d; // '-'

	// results per packet are capped at this many
	localparam int MAX_RESULTS = 32;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS);
	localparam logic [RES_CNT_W-1:0] RES_LAST = RES_CNT_W'(MAX_RESULTS - 1);

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_BODY,
		ST_CKHI,
		ST_CKLO,
		ST_SEQ_FETCH,
		ST_SEQ_CHK,
		ST_PL_FETCH,
		ST_PL_EMIT
	} state_t;

	typedef enum logic [1:0] {
		OSEL_NAK,
		OSEL_ACK,
		OSEL_DATA
	} out_sel_t;

	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_SEQ,
		PTR_ZERO,
		PTR_ADV
	} ptr_op_t;

	typedef struct packed {
		logic     start_body;
		logic     store_byte;
		logic     load_hi;
		logic     out_load;
		out_sel_t out_sel;
		ptr_op_t  ptr_op;
		logic     seq_clr;
		logic     seq_latch;
	} cmd_t;

	typedef struct packed {
		logic is_start;
		logic is_end;
		logic ck_match;
		logic cnt_zero;
		logic cnt_ge3;
		logic full_next;
		logic out_free;
		logic emit_last;
	} status_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b0;
		r.nib = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.ok  = 1'b1;
			r.nib = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r.ok  = 1'b1;
			r.nib = c[3:0] + 4'd9;
		end
		return r;
	endfunction

endpackage

FILE: rtl/rpr_ctrl.sv
// Controller for the RSP packet receiver: parse and readout state machine.
// Depends on rpr_pkg.
module rpr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  rpr_pkg::status_t sts,
	output rpr_pkg::cmd_t    cmd
);

	rpr_pkg::state_t state_q, state_d;
	logic acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rpr_pkg::ST_HUNT;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.out_sel    = rpr_pkg::OSEL_NAK;
		cmd.ptr_op     = rpr_pkg::PTR_HOLD;
		in_ready       = 1'b0;
		acc            = 1'b0;
		unique case (state_q)
			rpr_pkg::ST_HUNT: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (acc && sts.is_start) begin
					cmd.start_body = 1'b1;
					state_d        = rpr_pkg::ST_BODY;
				end
			end
			rpr_pkg::ST_BODY: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (acc) begin
					priority if (sts.is_start) begin
						cmd.start_body = 1'b1;
					end else if (sts.is_end) begin
						state_d = rpr_pkg::ST_CKHI;
					end else begin
						cmd.store_byte = 1'b1;
						// body would overflow: drop the packet
						if (sts.full_next)
							state_d = rpr_pkg::ST_HUNT;
					end
				end
			end
			rpr_pkg::ST_CKHI: begin
				in_ready = 1'b1;
				acc      = in_valid;
				if (acc) begin
					cmd.load_hi = 1'b1;
					state_d     = rpr_pkg::ST_CKLO;
				end
			end
			rpr_pkg::ST_CKLO: begin
				in_ready = sts.out_free;
				acc      = in_valid && sts.out_free;
				if (acc) begin
					cmd.out_load = 1'b1;
					priority if (!sts.ck_match) begin
						cmd.out_sel = rpr_pkg::OSEL_NAK;
						state_d     = rpr_pkg::ST_HUNT;
					end else if (sts.cnt_zero) begin
						cmd.out_sel = rpr_pkg::OSEL_ACK;
						state_d     = rpr_pkg::ST_HUNT;
					end else if (sts.cnt_ge3) begin
						cmd.out_sel = rpr_pkg::OSEL_ACK;
						cmd.ptr_op  = rpr_pkg::PTR_SEQ;
						state_d     = rpr_pkg::ST_SEQ_FETCH;
					end else begin
						cmd.out_sel = rpr_pkg::OSEL_ACK;
						cmd.ptr_op  = rpr_pkg::PTR_ZERO;
						cmd.seq_clr = 1'b1;
						state_d     = rpr_pkg::ST_PL_FETCH;
					end
				end
			end
			rpr_pkg::ST_SEQ_FETCH: begin
				state_d = rpr_pkg::ST_SEQ_CHK;
			end
			rpr_pkg::ST_SEQ_CHK: begin
				cmd.seq_latch = 1'b1;
				cmd.ptr_op    = rpr_pkg::PTR_ZERO;
				state_d       = rpr_pkg::ST_PL_FETCH;
			end
			rpr_pkg::ST_PL_FETCH: begin
				state_d = rpr_pkg::ST_PL_EMIT;
			end
			rpr_pkg::ST_PL_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = rpr_pkg::OSEL_DATA;
					cmd.ptr_op   = rpr_pkg::PTR_ADV;
					state_d      = sts.emit_last ? rpr_pkg::ST_HUNT : rpr_pkg::ST_PL_FETCH;
				end
			end
			default: state_d = rpr_pkg::ST_HUNT;
		endcase
	end

endmodule

FILE: rtl/rpr_dp.sv
// Datapath for the RSP packet receiver: checksum, body memory, readout
// pointer and output register. Depends on rpr_pkg.
module rpr_dp #(
	parameter int BODY_BYTES = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       in_byte,
	input  rpr_pkg::cmd_t    cmd,
	output rpr_pkg::status_t sts,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             out_kind,
	output logic [7:0]       out_value,
	output logic             out_last
);

	localparam int AW = $clog2(BODY_BYTES);

	logic [7:0]    sum_q;
	logic [AW-1:0] cnt_q;
	logic [3:0]    hi_q;
	logic          hibad_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] ptr_next;
	logic          seq_q;
	logic [rpr_pkg::RES_CNT_W-1:0] n_q;
	logic [7:0]    mem_q [BODY_BYTES];
	logic [7:0]    rdata_q;
	logic          ovalid_q;
	logic          okind_q;
	logic [7:0]    ovalue_q;
	logic          olast_q;
	rpr_pkg::hex_t hx;
	logic          data_kind;

	assign hx        = rpr_pkg::hex_decode(in_byte);
	// sequence characters go to the host, not to the command handler
	assign data_kind = !(seq_q && ptr_q < AW'(2));
	assign ptr_next  = (seq_q && ptr_q == AW'(1)) ? AW'(3) : ptr_q + AW'(1);

	always_comb begin
		sts.is_start  = in_byte == rpr_pkg::CH_START;
		sts.is_end    = in_byte == rpr_pkg::CH_END;
		sts.ck_match  = hx.ok && !hibad_q && ({hi_q, hx.nib} == sum_q);
		sts.cnt_zero  = cnt_q == '0;
		sts.cnt_ge3   = cnt_q >= AW'(3);
		sts.full_next = cnt_q == AW'(BODY_BYTES - 2);
		sts.out_free  = !ovalid_q || out_ready;
		sts.emit_last = (ptr_next >= cnt_q) || (n_q == rpr_pkg::RES_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			cnt_q    <= '0;
			hi_q     <= '0;
			hibad_q  <= 1'b0;
			ptr_q    <= '0;
			seq_q    <= 1'b0;
			n_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.start_body) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else if (cmd.store_byte) begin
				sum_q <= sum_q + in_byte;
				cnt_q <= cnt_q + AW'(1);
			end
			if (cmd.load_hi) begin
				hi_q    <= hx.nib;
				hibad_q <= !hx.ok;
			end
			unique case (cmd.ptr_op)
				rpr_pkg::PTR_HOLD: ptr_q <= ptr_q;
				rpr_pkg::PTR_SEQ:  ptr_q <= AW'(2);
				rpr_pkg::PTR_ZERO: ptr_q <= '0;
				rpr_pkg::PTR_ADV:  ptr_q <= ptr_next;
				default:           ptr_q <= ptr_q;
			endcase
			if (cmd.seq_clr)
				seq_q <= 1'b0;
			else if (cmd.seq_latch)
				seq_q <= rdata_q == rpr_pkg::CH_SEQ;
			if (cmd.out_load) begin
				ovalid_q <= 1'b1;
				if (cmd.out_sel == rpr_pkg::OSEL_ACK)
					n_q <= rpr_pkg::RES_CNT_W'(1);
				else if (cmd.out_sel == rpr_pkg::OSEL_DATA)
					n_q <= n_q + rpr_pkg::RES_CNT_W'(1);
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// body memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store_byte)
			mem_q[cnt_q] <= in_byte;
		rdata_q <= mem_q[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			unique case (cmd.out_sel)
				rpr_pkg::OSEL_NAK: begin
					okind_q  <= 1'b0;
					ovalue_q <= rpr_pkg::CH_NAK;
					olast_q  <= 1'b1;
				end
				rpr_pkg::OSEL_ACK: begin
					okind_q  <= 1'b0;
					ovalue_q <= rpr_pkg::CH_ACK;
					olast_q  <= sts.cnt_zero;
				end
				rpr_pkg::OSEL_DATA: begin
					okind_q  <= data_kind;
					ovalue_q <= rdata_q;
					olast_q  <= sts.emit_last;
				end
				default: begin
					okind_q  <= 1'b0;
					ovalue_q <= rpr_pkg::CH_NAK;
					olast_q  <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = ovalid_q;
	assign out_kind  = okind_q;
	assign out_value = ovalue_q;
	assign out_last  = olast_q;

endmodule

FILE: rtl/rsp_packet_receiver_unit.sv
// Top level of the RSP packet receiver: controller plus datapath.
// Depends on rpr_pkg, rpr_ctrl, rpr_dp.
//
//  channel | direction | signals                  | contents
//  s_*     | in        | tvalid tready tdata[7:0] | tdata: rx_byte
//  m_*     | out       | tvalid tready tdata[7:0] | tdata: value; tuser: kind; tlast: last
//
// Received bytes are taken one per cycle while a packet is parsed, save a
// stall on the checksum byte. After a good checksum the acknowledgement goes
// out at once; each further result needs a registered read of the body memory
// and then a load of the output register, and bodies of three or more bytes
// first get a ':' check. No input is taken during that readout.
// Reset is asynchronous; the body memory needs no clearing pass.
// A stalled output holds the checksum byte back; other bytes keep flowing.
module rsp_packet_receiver_unit #(
	parameter int BODY_BYTES = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] value
	output logic       m_tuser,  // [0] kind
	output logic       m_tlast
);

	rpr_pkg::cmd_t    cmd;
	rpr_pkg::status_t sts;

	rpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rpr_dp #(
		.BODY_BYTES (BODY_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_value (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

FILE: rtl/rpr_checker.sv
// Port-level checks for the RSP packet receiver, bound to the top level.
// Depends on rsp_packet_receiver_unit.
module rpr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("stalled result changed");

	// a result on offer is always fully defined
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !$isunknown({m_tdata, m_tuser, m_tlast}))
		else $error("result offered with unknown bits");

	// input is held off while a result other than the packet's last is on offer
	a_no_input_in_readout: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken during readout");

endmodule

bind rsp_packet_receiver_unit rpr_checker u_chk (.*);
